### hw/rtl/leapfrog_particle_wall_bounce_top_macros.svh
// Assertion macros for the RTL top level, the one file that carries checks.
`ifndef LEAPFROG_PARTICLE_WALL_BOUNCE_TOP_MACROS_SVH
`define LEAPFROG_PARTICLE_WALL_BOUNCE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Plain property, checked on every rising clock edge outside reset.
`define LPWB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lpwb assertion failed");
// Condition in one cycle implies consequence in the next.
`define LPWB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpwb assertion failed");
`else
`define LPWB_ASSERT(label, prop)
`define LPWB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/lpwb_pkg.sv
`timescale 1ns / 1ps
package lpwb_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_ITERS  = 16;
  localparam int CORDIC_SHIFT  = 30 - FRAC_BITS;
  localparam int SQRT_STEPS    = 32;
  localparam int DIV_STEPS     = FRAC_BITS + 1;

  localparam logic [1:0] LAST_AXIS = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR_SHARE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTITUTION    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_SPEED     = 3'd6;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_pos_z;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic signed [31:0] load_vel_z;
    logic [15:0]        rand_polar;
    logic [15:0]        rand_azimuth;
  } in_t;

  typedef struct packed {
    logic [23:0]        step_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               bounced;
    logic [30:0]        bounce_speed;
    logic               stopped;
  } out_t;

  // Datapath operations issued by the controller
  typedef enum logic [5:0] {
    OP_NONE, OP_CAPTURE, OP_MUL_GDT, OP_REWIND, OP_COUNT, OP_VEL_ADD,
    OP_MUL_VDT, OP_POS_ADD, OP_MUL_VV, OP_ACC_SQ, OP_SQRT_MAG, OP_SQRT_STEP,
    OP_MAG_SET, OP_MUL_MR, OP_SPEED, OP_STOP, OP_DIV_INIT, OP_DIV_STEP,
    OP_SPEC, OP_SQRT_ST, OP_ST_SET, OP_SQRT_CT, OP_CT_SET, OP_COR_INIT,
    OP_COR_STEP, OP_COR_DONE, OP_MUL_SC, OP_DIF0, OP_MUL_SS, OP_DIF2,
    OP_MUL_SSPEC, OP_MUL_SDIF, OP_MIX, OP_MUL_MIX, OP_VEL_MIX, OP_FLOOR,
    OP_EMIT, OP_EMIT_B
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] idx;   // axis
    logic [4:0] iter;  // step of an iterative unit
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic at_rest;
    logic y_neg;
    logic stop;
  } status_t;

  // atan(2^-i) in Q30 radians
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/leapfrog_particle_wall_bounce_top.sv
`timescale 1ns / 1ps
// Leapfrog push of one particle in Q16.16 with a partly diffuse ground at y = 0.
// One item is worked at a time through a single shared 33x33 multiplier, an
// iterative square root (32 steps), a restoring divider (17 steps per axis) and
// a 16-step CORDIC. The square roots and the three divisions make up most of the
// work of a full bounce. A new item is taken while the previous result still
// waits on the output register. Configuration writes land at once and are meant
// for an idle block.
`include "leapfrog_particle_wall_bounce_top_macros.svh"
module leapfrog_particle_wall_bounce_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lpwb_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lpwb_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [lpwb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i
);
  import lpwb_pkg::*;

  cmd_t    cmd;
  status_t status;

  lpwb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lpwb_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  // No datapath work while waiting for an input transfer
  `LPWB_ASSERT(a_idle_quiet, !in_ready_o || cmd.op == OP_NONE || cmd.op == OP_CAPTURE)
  // A result is written only into a free output slot
  `LPWB_ASSERT(a_emit_free, !(cmd.op == OP_EMIT || cmd.op == OP_EMIT_B) || !out_valid_o || out_ready_i)
  // A bounce result shows up flagged in the next cycle
  `LPWB_ASSERT_NEXT(a_emit_bounce, cmd.op == OP_EMIT_B, out_valid_o && out_data_o.bounced)
  // A bounce that does not stop leaves the particle on the ground
  `LPWB_ASSERT(a_floor, !(out_valid_o && out_data_o.bounced && !out_data_o.stopped) || out_data_o.pos_y == 32'sd0)

endmodule

### hw/rtl/lpwb_ctrl.sv
`timescale 1ns / 1ps
module lpwb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lpwb_pkg::status_t status_i,
  output lpwb_pkg::cmd_t    cmd_o
);
  import lpwb_pkg::*;

  localparam logic [5:0] S_IDLE     = 6'd0;
  localparam logic [5:0] S_DISP     = 6'd1;
  localparam logic [5:0] S_LD_MUL   = 6'd2;
  localparam logic [5:0] S_LD_SET   = 6'd3;
  localparam logic [5:0] S_G_MUL    = 6'd4;
  localparam logic [5:0] S_G_ADD    = 6'd5;
  localparam logic [5:0] S_P_MUL    = 6'd6;
  localparam logic [5:0] S_P_ADD    = 6'd7;
  localparam logic [5:0] S_CHECK    = 6'd8;
  localparam logic [5:0] S_SQ_MUL   = 6'd9;
  localparam logic [5:0] S_SQ_ACC   = 6'd10;
  localparam logic [5:0] S_MAG_INIT = 6'd11;
  localparam logic [5:0] S_MAG_RUN  = 6'd12;
  localparam logic [5:0] S_MAG_SET  = 6'd13;
  localparam logic [5:0] S_RS_MUL   = 6'd14;
  localparam logic [5:0] S_SPEED    = 6'd15;
  localparam logic [5:0] S_TEST     = 6'd16;
  localparam logic [5:0] S_DIV_INIT = 6'd17;
  localparam logic [5:0] S_DIV_RUN  = 6'd18;
  localparam logic [5:0] S_SPEC     = 6'd19;
  localparam logic [5:0] S_ST_INIT  = 6'd20;
  localparam logic [5:0] S_ST_RUN   = 6'd21;
  localparam logic [5:0] S_ST_SET   = 6'd22;
  localparam logic [5:0] S_CT_INIT  = 6'd23;
  localparam logic [5:0] S_CT_RUN   = 6'd24;
  localparam logic [5:0] S_CT_SET   = 6'd25;
  localparam logic [5:0] S_COR_INIT = 6'd26;
  localparam logic [5:0] S_COR_RUN  = 6'd27;
  localparam logic [5:0] S_COR_DONE = 6'd28;
  localparam logic [5:0] S_SC_MUL   = 6'd29;
  localparam logic [5:0] S_DIF0     = 6'd30;
  localparam logic [5:0] S_SS_MUL   = 6'd31;
  localparam logic [5:0] S_DIF2     = 6'd32;
  localparam logic [5:0] S_MX_MUL1  = 6'd33;
  localparam logic [5:0] S_MX_MUL2  = 6'd34;
  localparam logic [5:0] S_MX_SUM   = 6'd35;
  localparam logic [5:0] S_MX_MUL3  = 6'd36;
  localparam logic [5:0] S_MX_VEL   = 6'd37;
  localparam logic [5:0] S_FLOOR    = 6'd38;
  localparam logic [5:0] S_EMIT     = 6'd39;
  localparam logic [5:0] S_EMIT_B   = 6'd40;

  localparam logic [4:0] SQRT_LAST = 5'(SQRT_STEPS - 1);
  localparam logic [4:0] DIV_LAST  = 5'(DIV_STEPS - 1);
  localparam logic [4:0] COR_LAST  = 5'(CORDIC_ITERS - 1);

  logic [5:0] state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic [4:0] iter_q, iter_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OP_NONE;
    cmd_o.idx   = idx_q;
    cmd_o.iter  = iter_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = S_DISP;
        end
        idx_d  = 2'd0;
        iter_d = 5'd0;
      end
      S_DISP: begin
        if (!status_i.kind) begin
          state_d = S_LD_MUL;
        end else if (status_i.at_rest) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_COUNT;
          state_d  = S_G_MUL;
        end
      end
      S_LD_MUL: begin
        cmd_o.op = OP_MUL_GDT;
        state_d  = S_LD_SET;
      end
      S_LD_SET: begin
        cmd_o.op = OP_REWIND;
        if (idx_q == LAST_AXIS) begin
          idx_d   = 2'd0;
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_LD_MUL;
        end
      end
      S_G_MUL: begin
        cmd_o.op = OP_MUL_GDT;
        state_d  = S_G_ADD;
      end
      S_G_ADD: begin
        cmd_o.op = OP_VEL_ADD;
        if (idx_q == LAST_AXIS) begin
          idx_d   = 2'd0;
          state_d = S_P_MUL;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_G_MUL;
        end
      end
      S_P_MUL: begin
        cmd_o.op = OP_MUL_VDT;
        state_d  = S_P_ADD;
      end
      S_P_ADD: begin
        cmd_o.op = OP_POS_ADD;
        if (idx_q == LAST_AXIS) begin
          idx_d   = 2'd0;
          state_d = S_CHECK;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_P_MUL;
        end
      end
      S_CHECK: begin
        state_d = status_i.y_neg ? S_SQ_MUL : S_EMIT;
      end
      S_SQ_MUL: begin
        cmd_o.op = OP_MUL_VV;
        state_d  = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd_o.op = OP_ACC_SQ;
        if (idx_q == LAST_AXIS) begin
          idx_d   = 2'd0;
          state_d = S_MAG_INIT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_SQ_MUL;
        end
      end
      S_MAG_INIT: begin
        cmd_o.op = OP_SQRT_MAG;
        state_d  = S_MAG_RUN;
      end
      S_MAG_RUN: begin
        cmd_o.op = OP_SQRT_STEP;
        if (iter_q == SQRT_LAST) begin
          iter_d  = 5'd0;
          state_d = S_MAG_SET;
        end else begin
          iter_d = iter_q + 5'd1;
        end
      end
      S_MAG_SET: begin
        cmd_o.op = OP_MAG_SET;
        state_d  = S_RS_MUL;
      end
      S_RS_MUL: begin
        cmd_o.op = OP_MUL_MR;
        state_d  = S_SPEED;
      end
      S_SPEED: begin
        cmd_o.op = OP_SPEED;
        state_d  = S_TEST;
      end
      S_TEST: begin
        if (status_i.stop) begin
          cmd_o.op = OP_STOP;
          state_d  = S_EMIT_B;
        end else begin
          state_d = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        state_d  = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd_o.op = OP_DIV_STEP;
        if (iter_q == DIV_LAST) begin
          iter_d  = 5'd0;
          state_d = S_SPEC;
        end else begin
          iter_d = iter_q + 5'd1;
        end
      end
      S_SPEC: begin
        cmd_o.op = OP_SPEC;
        if (idx_q == LAST_AXIS) begin
          idx_d   = 2'd0;
          state_d = S_ST_INIT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_DIV_INIT;
        end
      end
      S_ST_INIT: begin
        cmd_o.op = OP_SQRT_ST;
        state_d  = S_ST_RUN;
      end
      S_ST_RUN: begin
        cmd_o.op = OP_SQRT_STEP;
        if (iter_q == SQRT_LAST) begin
          iter_d  = 5'd0;
          state_d = S_ST_SET;
        end else begin
          iter_d = iter_q + 5'd1;
        end
      end
      S_ST_SET: begin
        cmd_o.op = OP_ST_SET;
        state_d  = S_CT_INIT;
      end
      S_CT_INIT: begin
        cmd_o.op = OP_SQRT_CT;
        state_d  = S_CT_RUN;
      end
      S_CT_RUN: begin
        cmd_o.op = OP_SQRT_STEP;
        if (iter_q == SQRT_LAST) begin
          iter_d  = 5'd0;
          state_d = S_CT_SET;
        end else begin
          iter_d = iter_q + 5'd1;
        end
      end
      S_CT_SET: begin
        cmd_o.op = OP_CT_SET;
        state_d  = S_COR_INIT;
      end
      S_COR_INIT: begin
        cmd_o.op = OP_COR_INIT;
        state_d  = S_COR_RUN;
      end
      S_COR_RUN: begin
        cmd_o.op = OP_COR_STEP;
        if (iter_q == COR_LAST) begin
          iter_d  = 5'd0;
          state_d = S_COR_DONE;
        end else begin
          iter_d = iter_q + 5'd1;
        end
      end
      S_COR_DONE: begin
        cmd_o.op = OP_COR_DONE;
        state_d  = S_SC_MUL;
      end
      S_SC_MUL: begin
        cmd_o.op = OP_MUL_SC;
        state_d  = S_DIF0;
      end
      S_DIF0: begin
        cmd_o.op = OP_DIF0;
        state_d  = S_SS_MUL;
      end
      S_SS_MUL: begin
        cmd_o.op = OP_MUL_SS;
        state_d  = S_DIF2;
      end
      S_DIF2: begin
        cmd_o.op = OP_DIF2;
        state_d  = S_MX_MUL1;
      end
      S_MX_MUL1: begin
        cmd_o.op = OP_MUL_SSPEC;
        state_d  = S_MX_MUL2;
      end
      S_MX_MUL2: begin
        cmd_o.op = OP_MUL_SDIF;
        state_d  = S_MX_SUM;
      end
      S_MX_SUM: begin
        cmd_o.op = OP_MIX;
        state_d  = S_MX_MUL3;
      end
      S_MX_MUL3: begin
        cmd_o.op = OP_MUL_MIX;
        state_d  = S_MX_VEL;
      end
      S_MX_VEL: begin
        cmd_o.op = OP_VEL_MIX;
        if (idx_q == LAST_AXIS) begin
          idx_d   = 2'd0;
          state_d = S_FLOOR;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_MX_MUL1;
        end
      end
      S_FLOOR: begin
        cmd_o.op = OP_FLOOR;
        state_d  = S_EMIT_B;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_EMIT_B: begin
        if (slot_free) begin
          cmd_o.op    = OP_EMIT_B;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= 2'd0;
      iter_q      <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hw/rtl/lpwb_dpath.sv
`timescale 1ns / 1ps
module lpwb_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lpwb_pkg::cmd_t                   cmd_i,
  input  lpwb_pkg::in_t                    in_data_i,
  input  logic                             cfg_we_i,
  input  logic [lpwb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                      cfg_data_i,
  output lpwb_pkg::status_t                status_o,
  output lpwb_pkg::out_t                   out_data_o
);
  import lpwb_pkg::*;

  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic [32:0]        TWO_PI_Q30      = 33'd6746518852;
  localparam logic [63:0]        SQRT_TOP_BIT    = 64'h4000_0000_0000_0000;
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -66'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Configuration
  logic signed [31:0] g_q [3];
  logic [30:0]        dt_q;
  logic [16:0]        share_q;
  logic [16:0]        rest_q;
  logic [30:0]        stop_q;

  // Particle state and working registers
  in_t                in_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic [23:0]        cnt_q;
  logic               at_rest_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  logic [63:0]        sq_n_q;
  logic [63:0]        sq_res_q;
  logic [31:0]        mag_q;
  logic [30:0]        speed_q;
  logic [31:0]        div_r_q;
  logic [16:0]        div_quo_q;
  logic signed [17:0] spec_q [3];
  logic signed [17:0] dif_q [3];
  logic [16:0]        st_q;
  logic signed [32:0] cx_q;
  logic signed [32:0] cy_q;
  logic signed [33:0] cz_q;
  logic signed [17:0] cp_q;
  logic signed [17:0] sp_q;
  logic signed [18:0] mix_q;
  out_t               out_q;

  // Operand selection
  logic signed [31:0] vel_sel;
  logic signed [31:0] pos_sel;
  logic signed [31:0] ld_pos;
  logic signed [31:0] ld_vel;
  logic [31:0]        vabs;
  logic signed [17:0] one_minus_s;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  assign vel_sel     = vel_q[cmd_i.idx];
  assign pos_sel     = pos_q[cmd_i.idx];
  assign vabs        = vel_sel[31] ? (~vel_sel + 32'd1) : vel_sel;
  assign one_minus_s = 18'sd65536 - $signed({1'b0, share_q});

  always_comb begin
    case (cmd_i.idx)
      2'd0: begin
        ld_pos = in_q.load_pos_x;
        ld_vel = in_q.load_vel_x;
      end
      2'd1: begin
        ld_pos = in_q.load_pos_y;
        ld_vel = in_q.load_vel_y;
      end
      default: begin
        ld_pos = in_q.load_pos_z;
        ld_vel = in_q.load_vel_z;
      end
    endcase
  end

  // Shared multiplier, product registered
  always_comb begin
    case (cmd_i.op)
      OP_MUL_GDT: begin
        mul_a = 33'(g_q[cmd_i.idx]);
        mul_b = $signed({2'b00, dt_q});
      end
      OP_MUL_VDT: begin
        mul_a = 33'(vel_sel);
        mul_b = $signed({2'b00, dt_q});
      end
      OP_MUL_VV: begin
        mul_a = 33'(vel_sel);
        mul_b = 33'(vel_sel);
      end
      OP_MUL_MR: begin
        mul_a = $signed({1'b0, mag_q});
        mul_b = $signed({16'd0, rest_q});
      end
      OP_MUL_SC: begin
        mul_a = $signed({16'd0, st_q});
        mul_b = 33'(cp_q);
      end
      OP_MUL_SS: begin
        mul_a = $signed({16'd0, st_q});
        mul_b = 33'(sp_q);
      end
      OP_MUL_SSPEC: begin
        mul_a = $signed({16'd0, share_q});
        mul_b = 33'(spec_q[cmd_i.idx]);
      end
      OP_MUL_SDIF: begin
        mul_a = 33'(one_minus_s);
        mul_b = 33'(dif_q[cmd_i.idx]);
      end
      OP_MUL_MIX: begin
        mul_a = 33'(mix_q);
        mul_b = $signed({2'b00, speed_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Integer square root, two bits of radicand per step
  logic [63:0] sq_bit;
  logic [63:0] sq_sum;
  logic        sq_ge;

  assign sq_bit = SQRT_TOP_BIT >> {cmd_i.iter, 1'b0};
  assign sq_sum = sq_res_q + sq_bit;
  assign sq_ge  = (sq_n_q >= sq_sum);

  // Restoring divider for |v| << FRAC_BITS / mag, one quotient bit per step
  logic [32:0] div_t;
  logic        div_ge;
  logic [32:0] div_diff;
  logic signed [17:0] quo_s;

  assign div_t    = {div_r_q, (cmd_i.iter == 5'd0) ? vabs[0] : 1'b0};
  assign div_ge   = (div_t >= {1'b0, mag_q});
  assign div_diff = div_t - {1'b0, mag_q};
  assign quo_s    = $signed({1'b0, div_quo_q});

  // CORDIC rotation
  logic [46:0]        z_prod;
  logic signed [32:0] cx_sh;
  logic signed [32:0] cy_sh;
  logic signed [33:0] c_atan;
  logic signed [32:0] cx_fin;
  logic signed [32:0] cy_fin;

  assign z_prod = 47'(in_q.rand_azimuth[13:0]) * 47'(TWO_PI_Q30);
  assign cx_sh  = cx_q >>> cmd_i.iter;
  assign cy_sh  = cy_q >>> cmd_i.iter;
  assign c_atan = $signed({4'd0, atan_q30(cmd_i.iter)});
  assign cx_fin = cx_q >>> CORDIC_SHIFT;
  assign cy_fin = cy_q >>> CORDIC_SHIFT;

  // Mix of specular and diffuse terms
  logic signed [64:0] mix_sum;
  logic signed [64:0] mix_sh;

  assign mix_sum = 65'(acc_q) + 65'(prod_q);
  assign mix_sh  = mix_sum >>> FRAC_BITS;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q[0]  <= 32'sd0;
      g_q[1]  <= -32'sd642908;
      g_q[2]  <= 32'sd0;
      dt_q    <= 31'd1311;
      share_q <= 17'd22938;
      rest_q  <= 17'd52429;
      stop_q  <= 31'd3277;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRAVITY_X:      g_q[0]  <= cfg_data_i;
        CFG_GRAVITY_Y:      g_q[1]  <= cfg_data_i;
        CFG_GRAVITY_Z:      g_q[2]  <= cfg_data_i;
        CFG_TIME_STEP:      dt_q    <= cfg_data_i[30:0];
        CFG_SPECULAR_SHARE: share_q <= cfg_data_i[16:0];
        CFG_RESTITUTION:    rest_q  <= cfg_data_i[16:0];
        CFG_STOP_SPEED:     stop_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Particle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0]  <= '0;
      pos_q[1]  <= '0;
      pos_q[2]  <= '0;
      vel_q[0]  <= '0;
      vel_q[1]  <= '0;
      vel_q[2]  <= '0;
      cnt_q     <= '0;
      at_rest_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_REWIND: begin
          pos_q[cmd_i.idx] <= ld_pos;
          vel_q[cmd_i.idx] <= sat32(66'(ld_vel) - 66'(prod_q >>> (FRAC_BITS + 1)));
          cnt_q            <= '0;
          at_rest_q        <= 1'b0;
        end
        OP_COUNT: begin
          if (cnt_q != '1) cnt_q <= cnt_q + 24'd1;
        end
        OP_VEL_ADD: vel_q[cmd_i.idx] <= sat32(66'(vel_sel) + 66'(prod_q >>> FRAC_BITS));
        OP_POS_ADD: pos_q[cmd_i.idx] <= sat32(66'(pos_sel) + 66'(prod_q >>> FRAC_BITS));
        OP_VEL_MIX: vel_q[cmd_i.idx] <= sat32(66'(prod_q >>> FRAC_BITS));
        OP_STOP:    at_rest_q <= 1'b1;
        OP_FLOOR:   pos_q[1] <= '0;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: in_q <= in_data_i;
      OP_MUL_GDT, OP_MUL_VDT, OP_MUL_VV, OP_MUL_MR, OP_MUL_SC, OP_MUL_SS,
      OP_MUL_SSPEC, OP_MUL_MIX: prod_q <= mul_p[63:0];
      OP_MUL_SDIF: begin
        acc_q  <= prod_q;
        prod_q <= mul_p[63:0];
      end
      OP_ACC_SQ: acc_q <= ((cmd_i.idx == 2'd0) ? 64'sd0 : acc_q) + prod_q;
      OP_SQRT_MAG: begin
        sq_n_q   <= acc_q;
        sq_res_q <= '0;
      end
      OP_SQRT_ST: begin
        sq_n_q   <= {32'd0, in_q.rand_polar, 16'd0};
        sq_res_q <= '0;
      end
      OP_SQRT_CT: begin
        sq_n_q   <= {31'd0, 17'h1_0000 - {1'b0, in_q.rand_polar}, 16'd0};
        sq_res_q <= '0;
      end
      OP_SQRT_STEP: begin
        if (sq_ge) begin
          sq_n_q   <= sq_n_q - sq_sum;
          sq_res_q <= (sq_res_q >> 1) + sq_bit;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
      end
      OP_MAG_SET: mag_q <= sq_res_q[31:0];
      OP_ST_SET:  st_q  <= sq_res_q[16:0];
      OP_CT_SET:  dif_q[1] <= $signed({1'b0, sq_res_q[16:0]});
      OP_SPEED: begin
        // floor(mag * restitution), clipped to 31 bits
        if (prod_q[63:47] != '0) speed_q <= 31'h7FFF_FFFF;
        else speed_q <= prod_q[46:16];
      end
      OP_DIV_INIT: begin
        div_r_q   <= vabs >> 1;
        div_quo_q <= '0;
      end
      OP_DIV_STEP: begin
        div_r_q   <= div_ge ? div_diff[31:0] : div_t[31:0];
        div_quo_q <= {div_quo_q[15:0], div_ge};
      end
      OP_SPEC: begin
        // truncation toward zero; y is mirrored
        if (mag_q == '0) spec_q[cmd_i.idx] <= '0;
        else if (vel_sel[31] ^ (cmd_i.idx == 2'd1)) spec_q[cmd_i.idx] <= -quo_s;
        else spec_q[cmd_i.idx] <= quo_s;
      end
      OP_COR_INIT: begin
        cx_q <= CORDIC_GAIN_Q30;
        cy_q <= '0;
        cz_q <= $signed({3'd0, z_prod[46:16]});
      end
      OP_COR_STEP: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - cy_sh;
          cy_q <= cy_q + cx_sh;
          cz_q <= cz_q - c_atan;
        end else begin
          cx_q <= cx_q + cy_sh;
          cy_q <= cy_q - cx_sh;
          cz_q <= cz_q + c_atan;
        end
      end
      OP_COR_DONE: begin
        case (in_q.rand_azimuth[15:14])
          QUAD_I: begin
            cp_q <= cx_fin[17:0];
            sp_q <= cy_fin[17:0];
          end
          QUAD_II: begin
            cp_q <= -cy_fin[17:0];
            sp_q <= cx_fin[17:0];
          end
          QUAD_III: begin
            cp_q <= -cx_fin[17:0];
            sp_q <= -cy_fin[17:0];
          end
          QUAD_IV: begin
            cp_q <= cy_fin[17:0];
            sp_q <= -cx_fin[17:0];
          end
          default: ;
        endcase
      end
      OP_DIF0: dif_q[0] <= 18'(prod_q >>> FRAC_BITS);
      OP_DIF2: dif_q[2] <= 18'(prod_q >>> FRAC_BITS);
      OP_MIX:  mix_q    <= mix_sh[18:0];
      OP_EMIT, OP_EMIT_B: begin
        out_q.step_index   <= cnt_q;
        out_q.pos_x        <= pos_q[0];
        out_q.pos_y        <= pos_q[1];
        out_q.pos_z        <= pos_q[2];
        out_q.vel_x        <= vel_q[0];
        out_q.vel_y        <= vel_q[1];
        out_q.vel_z        <= vel_q[2];
        out_q.bounced      <= (cmd_i.op == OP_EMIT_B);
        out_q.bounce_speed <= (cmd_i.op == OP_EMIT_B) ? speed_q : 31'd0;
        out_q.stopped      <= at_rest_q;
      end
      default: ;
    endcase
  end

  assign status_o.kind    = in_q.kind;
  assign status_o.at_rest = at_rest_q;
  assign status_o.y_neg   = pos_q[1][31];
  assign status_o.stop    = (speed_q < stop_q);
  assign out_data_o       = out_q;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lpwb_pkg::*;

  // Particle state and register copy used to predict every result.
  class particle_scoreboard;
    longint grav[3];
    longint dt, spec_share, rest, stop_spd;
    longint pos[3], vel[3];
    int unsigned steps;
    bit frozen;
    out_t pending[$];
    int errors;

    function new();
      grav[0] = 0; grav[1] = -642908; grav[2] = 0;
      dt = 1311; spec_share = 22938; rest = 52429; stop_spd = 3277;
      for (int i = 0; i < 3; i++) begin
        pos[i] = 0;
        vel[i] = 0;
      end
      steps = 0; frozen = 0; errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        CFG_GRAVITY_X: grav[0] = longint'(signed'(d));
        CFG_GRAVITY_Y: grav[1] = longint'(signed'(d));
        CFG_GRAVITY_Z: grav[2] = longint'(signed'(d));
        CFG_TIME_STEP: dt = longint'(d[30:0]);
        CFG_SPECULAR_SHARE: spec_share = longint'(d[16:0]);
        CFG_RESTITUTION: rest = longint'(d[16:0]);
        CFG_STOP_SPEED: stop_spd = longint'(d[30:0]);
        default: ;
      endcase
    endfunction

    // arithmetic shift right (floor)
    function longint fl(longint v, int s);
      return v >>> s;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function void sin_cos(logic [15:0] turn, output longint c, output longint s);
      longint z, x, y, xn;
      longint atan_tab[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768};
      z = (longint'(turn[13:0]) * 64'sd6746518852) >>> 16;
      x = 652032874; y = 0;
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          xn = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
        end else begin
          xn = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
        end
        x = xn;
      end
      x = x >>> 14; y = y >>> 14;
      case (turn[15:14])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function out_t snapshot(bit b, longint bs);
      out_t o;
      o.step_index = steps[23:0];
      o.pos_x = pos[0][31:0]; o.pos_y = pos[1][31:0]; o.pos_z = pos[2][31:0];
      o.vel_x = vel[0][31:0]; o.vel_y = vel[1][31:0]; o.vel_z = vel[2][31:0];
      o.bounced = b; o.bounce_speed = bs[30:0]; o.stopped = frozen;
      return o;
    endfunction

    // note an accepted input transfer and queue its expected result
    function void note_input(in_t it);
      longint unsigned sq, mag;
      longint spd, r1, st, ct, cp, sp, mix;
      longint spv[3], dif[3];
      if (!it.kind) begin
        pos[0] = longint'(it.load_pos_x);
        pos[1] = longint'(it.load_pos_y);
        pos[2] = longint'(it.load_pos_z);
        vel[0] = clip32(longint'(it.load_vel_x) - fl(grav[0] * dt, 17));
        vel[1] = clip32(longint'(it.load_vel_y) - fl(grav[1] * dt, 17));
        vel[2] = clip32(longint'(it.load_vel_z) - fl(grav[2] * dt, 17));
        steps = 0; frozen = 0;
        pending.push_back(snapshot(0, 0));
        return;
      end
      if (frozen) begin
        pending.push_back(snapshot(0, 0));
        return;
      end
      if (steps < 24'hFFFFFF) steps++;
      for (int i = 0; i < 3; i++) vel[i] = clip32(vel[i] + fl(grav[i] * dt, 16));
      for (int i = 0; i < 3; i++) pos[i] = clip32(pos[i] + fl(vel[i] * dt, 16));
      if (pos[1] >= 0) begin
        pending.push_back(snapshot(0, 0));
        return;
      end
      sq = 0;
      for (int i = 0; i < 3; i++) sq += longint'(vel[i] * vel[i]);
      mag = root(sq);
      spd = fl(longint'(mag) * rest, 16);
      if (spd > 64'sh7FFFFFFF) spd = 64'sh7FFFFFFF;
      if (spd < stop_spd) begin
        frozen = 1;
        pending.push_back(snapshot(1, spd));
        return;
      end
      for (int i = 0; i < 3; i++)
        spv[i] = (mag == 0) ? 0 : (vel[i] * 65536) / longint'(mag);
      spv[1] = -spv[1];
      r1 = longint'(it.rand_polar);
      st = longint'(root(longint'(r1) << 16));
      ct = longint'(root(longint'(65536 - r1) << 16));
      sin_cos(it.rand_azimuth, cp, sp);
      dif[0] = fl(st * cp, 16); dif[1] = ct; dif[2] = fl(st * sp, 16);
      for (int i = 0; i < 3; i++) begin
        mix = fl(spec_share * spv[i] + (65536 - spec_share) * dif[i], 16);
        vel[i] = clip32(fl(mix * spd, 16));
      end
      pos[1] = 0;
      pending.push_back(snapshot(1, spd));
    endfunction

    // compare one output transfer with the oldest expectation
    function void check_result(out_t got);
      out_t w;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.step_index !== w.step_index) begin
        $error("step_index exp %0d got %0d", w.step_index, got.step_index); errors++; end
      if (got.pos_x !== w.pos_x) begin
        $error("pos_x exp %0d got %0d", w.pos_x, got.pos_x); errors++; end
      if (got.pos_y !== w.pos_y) begin
        $error("pos_y exp %0d got %0d", w.pos_y, got.pos_y); errors++; end
      if (got.pos_z !== w.pos_z) begin
        $error("pos_z exp %0d got %0d", w.pos_z, got.pos_z); errors++; end
      if (got.vel_x !== w.vel_x) begin
        $error("vel_x exp %0d got %0d", w.vel_x, got.vel_x); errors++; end
      if (got.vel_y !== w.vel_y) begin
        $error("vel_y exp %0d got %0d", w.vel_y, got.vel_y); errors++; end
      if (got.vel_z !== w.vel_z) begin
        $error("vel_z exp %0d got %0d", w.vel_z, got.vel_z); errors++; end
      if (got.bounced !== w.bounced) begin
        $error("bounced exp %0d got %0d", w.bounced, got.bounced); errors++; end
      if (got.bounce_speed !== w.bounce_speed) begin
        $error("bounce_speed exp %0d got %0d", w.bounce_speed, got.bounce_speed);
        errors++;
      end
      if (got.stopped !== w.stopped) begin
        $error("stopped exp %0d got %0d", w.stopped, got.stopped); errors++; end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  out_t out_data_o;
  logic cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  particle_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_out = 0;

  always #10 clk_i = ~clk_i;

  leapfrog_particle_wall_bounce_top u_top (.*);

  // output side: sample at rising edge, drive ready at falling edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  always @(negedge clk_i) begin
    out_ready_i <= !hold_out && ($urandom_range(99) >= recv_idle_pct);
  end

  // one input transfer, with random idle cycles in front; valid stays up
  // after the transfer until the next idle cycle or the next item
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(it);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic in_t load_item(int scale);
    in_t it;
    it = '0;
    it.kind = 0;
    it.load_pos_x = $signed($urandom) >>> scale;
    it.load_pos_y = $urandom_range(20) << 16;
    it.load_pos_z = $signed($urandom) >>> scale;
    it.load_vel_x = $signed($urandom) >>> (scale + 4);
    it.load_vel_y = $signed($urandom) >>> (scale + 4);
    it.load_vel_z = $signed($urandom) >>> (scale + 4);
    it.rand_polar = 16'($urandom); it.rand_azimuth = 16'($urandom);
    return it;
  endfunction

  function automatic in_t step_item();
    in_t it;
    it = '0;
    it.kind = 1;
    it.load_pos_x = $urandom; it.load_pos_y = $urandom; it.load_pos_z = $urandom;
    it.load_vel_x = $urandom; it.load_vel_y = $urandom; it.load_vel_z = $urandom;
    it.rand_polar = 16'($urandom); it.rand_azimuth = 16'($urandom);
    return it;
  endfunction

  // random config set: extremes mixed with realistic values
  task automatic random_config(int sel);
    write_reg(CFG_GRAVITY_X, sel == 0 ? 32'h8000_0000 : $urandom_range(200000) - 100000);
    write_reg(CFG_GRAVITY_Y, sel == 0 ? 32'h7FFF_FFFF :
              -$signed($urandom_range(1500000)));
    write_reg(CFG_GRAVITY_Z, sel == 0 ? 32'h0 : $urandom_range(200000) - 100000);
    write_reg(CFG_TIME_STEP, sel == 0 ? 32'h7FFF_FFFF : $urandom_range(8000, 200));
    write_reg(CFG_SPECULAR_SHARE, sel == 0 ? 32'h1_0000 : (sel == 1 ? 32'h1_FFFF :
              $urandom_range(65536)));
    write_reg(CFG_RESTITUTION, sel == 0 ? 32'h0 : (sel == 1 ? 32'h1_FFFF :
              $urandom_range(65536)));
    write_reg(CFG_STOP_SPEED, sel == 0 ? 32'h7FFF_FFFF : (sel == 1 ? 32'h0 :
              $urandom_range(20000)));
  endtask

  initial begin
    in_t it;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed: default registers, drop from rest
    send_idle_pct = 9; recv_idle_pct = 53;
    it = '0; it.kind = 0; it.load_pos_y = 32'sh0001_0000;
    send_item(it);
    it = step_item(); it.rand_polar = 16'h0000; it.rand_azimuth = 16'h0000; send_item(it);
    it = step_item(); it.rand_polar = 16'hFFFF; it.rand_azimuth = 16'hFFFF; send_item(it);
    for (int i = 0; i < 10; i++) begin
      it = step_item(); it.rand_azimuth = 16'(16'h4000 * i); send_item(it);
    end
    // extremes of load fields
    it = '0; it.kind = 0;
    it.load_pos_x = 32'sh7FFF_FFFF; it.load_pos_y = 32'sh8000_0000;
    it.load_pos_z = 32'sh8000_0000; it.load_vel_x = 32'sh8000_0000;
    it.load_vel_y = 32'sh7FFF_FFFF; it.load_vel_z = 32'sh7FFF_FFFF;
    send_item(it);
    send_item(step_item()); send_item(step_item());
    it = '1; it.kind = 0; it.load_pos_y = 32'sh0000_0100; send_item(it);
    send_item(step_item()); send_item(step_item());
    drain();
    // extreme registers: zero restitution with the highest stop speed, then zero stop speed
    random_config(0);
    it = '0; send_item(it); send_item(step_item()); send_item(step_item());
    drain();
    random_config(1);
    it = '0; it.load_pos_y = -1; send_item(it);
    send_item(step_item()); send_item(step_item());
    drain();

    // random phases over the three idle settings
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle_pct = 53; recv_idle_pct = 9; end
      if (ph == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
      random_config(ph == 11 ? 1 : 2);
      for (int n = 0; n < 170; n++) begin
        if ($urandom_range(99) < 6) send_item(load_item($urandom_range(12, 1)));
        else send_item(step_item());
        if (ph == 5 && n == 20) begin
          fork
            begin
              hold_out = 1;
              repeat (1500) @(posedge clk_i);
              hold_out = 0;
            end
          join_none
        end
      end
      drain();
    end

    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/lpwb_pkg.sv
hw/rtl/lpwb_ctrl.sv
hw/rtl/lpwb_dpath.sv
hw/rtl/leapfrog_particle_wall_bounce_top.sv
test/tb_top.sv
